// ===== sv/drucker_prager_yield_stress_defines.svh =====
// Assertion macros used by the checker file of this block.
`ifndef DRUCKER_PRAGER_YIELD_STRESS_DEFINES_SVH
`define DRUCKER_PRAGER_YIELD_STRESS_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define DPY_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DPY_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/dpy_pkg.sv =====
package dpy_pkg;

	localparam int unsigned SQRT_CELLS = 32;
	localparam int unsigned DIV_CELLS  = 31;
	// Input register, blend sum, square, root row, first divide row, K multiply,
	// second divide row, final multiply, sum and clamp.
	localparam int unsigned PIPE_DEPTH = 3 + SQRT_CELLS + DIV_CELLS + 1 + DIV_CELLS + 2;

	localparam logic [16:0] ONE_Q16       = 17'd65536;
	localparam logic [31:0] TWO_SQRT3_Q30 = 32'd3719550786;
	localparam logic [31:0] THREE_Q30     = 32'd3221225472;

	localparam logic [2:0] REG_COH_INTACT  = 3'd0;
	localparam logic [2:0] REG_COH_SOFT    = 3'd1;
	localparam logic [2:0] REG_FRIC_INTACT = 3'd2;
	localparam logic [2:0] REG_FRIC_SOFT   = 3'd3;
	localparam logic [2:0] REG_MIN_STRESS  = 3'd4;
	localparam logic [2:0] REG_THREE_D     = 3'd5;

	typedef struct packed {
		logic signed [31:0] pressure;
		logic [16:0]        weakening_ratio;
	} point_t;

	typedef struct packed {
		logic signed [31:0] yield_stress;
		logic               tensile_failure;
		logic [22:0]        effective_friction;
	} result_t;

	typedef struct packed {
		logic signed [31:0] cohesion_intact;
		logic signed [31:0] cohesion_softened;
		logic [22:0]        friction_intact;
		logic [22:0]        friction_softened;
		logic signed [31:0] minimum_strength;
		logic               three_dimensional;
	} cfg_t;

	typedef struct packed {
		logic [32:0] rem;
		logic [31:0] root;
		logic [63:0] rad;
	} sqrt_step_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] den;
		logic [30:0] num_low;
		logic [30:0] quo;
	} div_step_t;

	// Loads a divide row; the quotient must stay below 2^31.
	function automatic div_step_t div_start(input logic [63:0] num, input logic [31:0] den);
		div_step_t s;
		s.rem     = num[62:31];
		s.den     = den;
		s.num_low = num[30:0];
		s.quo     = '0;
		return s;
	endfunction

endpackage

// ===== sv/dpy_regs.sv =====
module dpy_regs import dpy_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output cfg_t        cfg
);

	cfg_t        cfg_q;
	logic [2:0]  idx;

	assign idx = paddr[4:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_COH_INTACT:  cfg_q.cohesion_intact   <= pwdata;
				REG_COH_SOFT:    cfg_q.cohesion_softened <= pwdata;
				REG_FRIC_INTACT: cfg_q.friction_intact   <= pwdata[22:0];
				REG_FRIC_SOFT:   cfg_q.friction_softened <= pwdata[22:0];
				REG_MIN_STRESS:  cfg_q.minimum_strength  <= pwdata;
				REG_THREE_D:     cfg_q.three_dimensional <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_COH_INTACT:  prdata = cfg_q.cohesion_intact;
			REG_COH_SOFT:    prdata = cfg_q.cohesion_softened;
			REG_FRIC_INTACT: prdata = {9'd0, cfg_q.friction_intact};
			REG_FRIC_SOFT:   prdata = {9'd0, cfg_q.friction_softened};
			REG_MIN_STRESS:  prdata = cfg_q.minimum_strength;
			REG_THREE_D:     prdata = {31'd0, cfg_q.three_dimensional};
			default:         prdata = '0;
		endcase
	end

endmodule

// ===== sv/dpy_sqrt_cell.sv =====
module dpy_sqrt_cell import dpy_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  sqrt_step_t d,
	output sqrt_step_t q
);

	logic [34:0] cur;
	logic [34:0] trial;
	logic [34:0] diff;
	logic        ge;
	sqrt_step_t  nxt;

	// One result bit: bring down two radicand bits and try 4*root+1.
	always_comb begin
		cur      = {d.rem, d.rad[63:62]};
		trial    = {1'b0, d.root, 2'b01};
		diff     = cur - trial;
		ge       = cur >= trial;
		nxt.rem  = ge ? diff[32:0] : cur[32:0];
		nxt.root = {d.root[30:0], ge};
		nxt.rad  = {d.rad[61:0], 2'b00};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

// ===== sv/dpy_div_cell.sv =====
module dpy_div_cell import dpy_pkg::*; (
	input  logic      clk,
	input  logic      en,
	input  div_step_t d,
	output div_step_t q
);

	logic [32:0] trial;
	logic [32:0] diff;
	logic        ge;
	div_step_t   nxt;

	// One quotient bit of a restoring divide.
	always_comb begin
		trial       = {d.rem, d.num_low[30]};
		diff        = trial - {1'b0, d.den};
		ge          = trial >= {1'b0, d.den};
		nxt.rem     = ge ? diff[31:0] : trial[31:0];
		nxt.den     = d.den;
		nxt.num_low = {d.num_low[29:0], 1'b0};
		nxt.quo     = {d.quo[29:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

// ===== sv/drucker_prager_yield_stress.sv =====
// Channel     Direction  Handshake                  Payload
// point       in         point_valid / point_stall  point_t  (pressure, weakening_ratio)
// result      out        result_valid / result_stall result_t (yield_stress, tensile_failure,
//                                                             effective_friction)
// config      in         APB write (psel, penable)  pwdata at paddr = 4 * register index
//
// One request is taken per cycle while point_stall is low; each result passes through
// the 32-cell square-root row and the two 31-cell divide rows, one result bit per
// cell, before it reaches the output register.
// arst_n clears the valid bits, the output and skid flags and the configuration
// registers at once; the data path itself is not reset.
// A result held by result_stall is backed by one skid entry; point_stall rises as a
// second result lands behind a held one, and the whole row freezes.
module drucker_prager_yield_stress import dpy_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        point_valid,
	output logic        point_stall,
	input  point_t      point,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef struct packed {
		logic signed [31:0] pressure;
		logic signed [31:0] coh;
		logic [22:0]        fric;
	} side_a_t;

	typedef struct packed {
		logic signed [31:0] pressure;
		logic signed [31:0] coh;
	} side_b_t;

	typedef struct packed {
		logic signed [31:0] pressure;
		logic signed [31:0] coh;
		logic [30:0]        sin30;
		logic [30:0]        cos30;
	} side_c_t;

	cfg_t cfg;

	dpy_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// The whole row advances together whenever the skid entry is free.
	logic en;
	logic accept;
	logic skid_full_q;
	logic [PIPE_DEPTH-1:0] vld_q;

	assign en          = !skid_full_q;
	assign point_stall = skid_full_q;
	assign accept      = point_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], accept};
		end
	end

	// Stage 1: clip the ratio at one and form the four blend products.
	logic [16:0]        ratio;
	logic [16:0]        inv_ratio;
	logic signed [49:0] coh_a_s1, coh_b_s1;
	logic [39:0]        fric_a_s1, fric_b_s1;
	logic signed [31:0] pressure_s1;

	assign ratio     = (point.weakening_ratio > ONE_Q16) ? ONE_Q16 : point.weakening_ratio;
	assign inv_ratio = ONE_Q16 - ratio;

	always_ff @(posedge clk) begin
		if (en) begin
			coh_a_s1    <= cfg.cohesion_intact * $signed({1'b0, inv_ratio});
			coh_b_s1    <= cfg.cohesion_softened * $signed({1'b0, ratio});
			fric_a_s1   <= cfg.friction_intact * inv_ratio;
			fric_b_s1   <= cfg.friction_softened * ratio;
			pressure_s1 <= point.pressure;
		end
	end

	// Stage 2: sum and round the blends to nearest, halves up.
	logic signed [50:0] coh_sum;
	logic [40:0]        fric_sum;
	logic signed [31:0] coh_s2, pressure_s2;
	logic [22:0]        fric_s2;

	assign coh_sum  = 51'(coh_a_s1) + 51'(coh_b_s1) + 51'sd32768;
	assign fric_sum = 41'(fric_a_s1) + 41'(fric_b_s1) + 41'd32768;

	always_ff @(posedge clk) begin
		if (en) begin
			coh_s2      <= coh_sum[47:16];
			fric_s2     <= fric_sum[38:16];
			pressure_s2 <= pressure_s1;
		end
	end

	// Stage 3: square the friction for the radicand (2^32 + f^2) << 16.
	logic [45:0]        sq_s3;
	logic [22:0]        fric_s3;
	logic signed [31:0] coh_s3, pressure_s3;
	logic [46:0]        rad_sum;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3       <= fric_s2 * fric_s2;
			fric_s3     <= fric_s2;
			coh_s3      <= coh_s2;
			pressure_s3 <= pressure_s2;
		end
	end

	assign rad_sum = 47'h1_0000_0000 + {1'b0, sq_s3};

	// Square-root row: one root bit per cell, sideband travels alongside.
	sqrt_step_t sq_chain [SQRT_CELLS+1];
	side_a_t    side_a_in;
	side_a_t    side_a   [1:SQRT_CELLS];

	assign sq_chain[0].rem  = '0;
	assign sq_chain[0].root = '0;
	assign sq_chain[0].rad  = {1'b0, rad_sum, 16'h0000};
	assign side_a_in        = '{pressure: pressure_s3, coh: coh_s3, fric: fric_s3};

	for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
		dpy_sqrt_cell u_cell (
			.clk (clk),
			.en  (en),
			.d   (sq_chain[i]),
			.q   (sq_chain[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_a[1] <= side_a_in;
			for (int i = 2; i <= SQRT_CELLS; i++) begin
				side_a[i] <= side_a[i-1];
			end
		end
	end

	// First divide rows: sin = f*2^38/R and cos = 2^54/R, both rounded.
	logic [31:0] root;
	logic [31:0] half_root;
	side_a_t     side_a_end;
	logic [63:0] num_sin, num_cos;

	assign root       = sq_chain[SQRT_CELLS].root;
	assign side_a_end = side_a[SQRT_CELLS];
	assign half_root  = {1'b0, root[31:1]};
	assign num_sin    = {3'b000, side_a_end.fric, 38'd0} + {32'd0, half_root};
	assign num_cos    = 64'h0040_0000_0000_0000 + {32'd0, half_root};

	div_step_t sin_chain [DIV_CELLS+1];
	div_step_t cos_chain [DIV_CELLS+1];
	side_b_t   side_b_in;
	side_b_t   side_b    [1:DIV_CELLS];

	assign sin_chain[0] = div_start(num_sin, root);
	assign cos_chain[0] = div_start(num_cos, root);
	assign side_b_in    = '{pressure: side_a_end.pressure, coh: side_a_end.coh};

	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div1
		dpy_div_cell u_sin (
			.clk (clk),
			.en  (en),
			.d   (sin_chain[i]),
			.q   (sin_chain[i+1])
		);
		dpy_div_cell u_cos (
			.clk (clk),
			.en  (en),
			.d   (cos_chain[i]),
			.q   (cos_chain[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_b[1] <= side_b_in;
			for (int i = 2; i <= DIV_CELLS; i++) begin
				side_b[i] <= side_b[i-1];
			end
		end
	end

	// Stage 4: scale by 2*sqrt(3) and form T = 3 - sin for the 3D calibration.
	logic [30:0]        sin30, cos30;
	logic [62:0]        ks_s4, kc_s4;
	logic [31:0]        t_s4;
	logic [30:0]        sin_s4, cos_s4;
	logic signed [31:0] coh_s4, pressure_s4;

	assign sin30 = sin_chain[DIV_CELLS].quo;
	assign cos30 = cos_chain[DIV_CELLS].quo;

	always_ff @(posedge clk) begin
		if (en) begin
			ks_s4       <= TWO_SQRT3_Q30 * sin30;
			kc_s4       <= TWO_SQRT3_Q30 * cos30;
			t_s4        <= THREE_Q30 - {1'b0, sin30};
			sin_s4      <= sin30;
			cos_s4      <= cos30;
			coh_s4      <= side_b[DIV_CELLS].coh;
			pressure_s4 <= side_b[DIV_CELLS].pressure;
		end
	end

	// Second divide rows: dpF = K*sin/T and G = K*cos/T, rounded.
	logic [63:0] num_dpf, num_g;

	assign num_dpf = {1'b0, ks_s4} + {33'd0, t_s4[31:1]};
	assign num_g   = {1'b0, kc_s4} + {33'd0, t_s4[31:1]};

	div_step_t dpf_chain [DIV_CELLS+1];
	div_step_t g_chain   [DIV_CELLS+1];
	side_c_t   side_c_in;
	side_c_t   side_c    [1:DIV_CELLS];

	assign dpf_chain[0] = div_start(num_dpf, t_s4);
	assign g_chain[0]   = div_start(num_g, t_s4);
	assign side_c_in    = '{pressure: pressure_s4, coh: coh_s4, sin30: sin_s4, cos30: cos_s4};

	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div2
		dpy_div_cell u_dpf (
			.clk (clk),
			.en  (en),
			.d   (dpf_chain[i]),
			.q   (dpf_chain[i+1])
		);
		dpy_div_cell u_g (
			.clk (clk),
			.en  (en),
			.d   (g_chain[i]),
			.q   (g_chain[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_c[1] <= side_c_in;
			for (int i = 2; i <= DIV_CELLS; i++) begin
				side_c[i] <= side_c[i-1];
			end
		end
	end

	// Stage 5: pick the calibration and form both strength products.
	side_c_t            side_c_end;
	logic [30:0]        dpf, g_coef;
	logic signed [63:0] prod_p_s5, prod_c_s5;
	logic [30:0]        dpf_s5;

	assign side_c_end = side_c[DIV_CELLS];
	assign dpf    = cfg.three_dimensional ? dpf_chain[DIV_CELLS].quo : side_c_end.sin30;
	assign g_coef = cfg.three_dimensional ? g_chain[DIV_CELLS].quo : side_c_end.cos30;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_p_s5 <= $signed({1'b0, dpf}) * side_c_end.pressure;
			prod_c_s5 <= $signed({1'b0, g_coef}) * side_c_end.coh;
			dpf_s5    <= dpf;
		end
	end

	// Stage 6: round back to Q16.16, saturate, flag tension and clamp.
	logic signed [64:0] acc;
	logic signed [34:0] strength;
	logic signed [31:0] sat;
	logic [31:0]        eff_sum;
	result_t            res_s6;

	assign acc      = 65'(prod_p_s5) + 65'(prod_c_s5) + 65'sd536870912;
	assign strength = acc[64:30];
	assign eff_sum  = {1'b0, dpf_s5} + 32'd8192;

	always_comb begin
		if (strength[34:31] == 4'b0000 || strength[34:31] == 4'b1111) begin
			sat = strength[31:0];
		end else if (strength[34]) begin
			sat = 32'sh8000_0000;
		end else begin
			sat = 32'sh7fff_ffff;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s6.yield_stress       <= (sat < cfg.minimum_strength) ?
				cfg.minimum_strength : sat;
			res_s6.tensile_failure    <= sat[31] || (sat == 32'sd0);
			res_s6.effective_friction <= {5'd0, eff_sum[31:14]};
		end
	end

	// Output register with one skid entry behind it.
	logic    v_last;
	logic    out_take;
	logic    out_valid_q;
	result_t out_q, skid_q;

	assign v_last       = vld_q[PIPE_DEPTH-1];
	assign out_take     = out_valid_q && !result_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (en && v_last) begin
			if (!out_valid_q || out_take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_full_q <= 1'b1;
			end
		end else if (skid_full_q && out_take) begin
			skid_full_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_last) begin
			if (!out_valid_q || out_take) begin
				out_q <= res_s6;
			end else begin
				skid_q <= res_s6;
			end
		end else if (skid_full_q && out_take) begin
			out_q <= skid_q;
		end
	end

endmodule

// ===== sv/dpy_checker.sv =====
`include "drucker_prager_yield_stress_defines.svh"

module dpy_checker import dpy_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        point_valid,
	input logic        point_stall,
	input point_t      point,
	input logic        result_valid,
	input logic        result_stall,
	input result_t     result,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [4:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);

	`DPY_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result), "stalled result changed or dropped")

	`DPY_ASSERT_IMP(a_positive_unless_tensile, clk, arst_n, result_valid && !result.tensile_failure, result.yield_stress > 32'sd0, "yield stress not positive without tensile flag")

	`DPY_ASSERT_IMP(a_stall_cause, clk, arst_n, $rose(point_stall), $past(result_valid && result_stall), "request stall rose without a held result")

	`DPY_ASSERT_IMP(a_stall_needs_result, clk, arst_n, point_stall, result_valid, "request stalled while no result is pending")

endmodule

bind drucker_prager_yield_stress dpy_checker u_dpy_checker (.*);

// ===== verif/tb_top.sv =====
module tb_top;
	import dpy_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        point_valid;
	logic        point_stall;
	point_t      point;
	logic        result_valid;
	logic        result_stall;
	result_t     result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	drucker_prager_yield_stress DUT (
		.clk(clk), .arst_n(arst_n),
		.point_valid(point_valid), .point_stall(point_stall), .point(point),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Waits at the end allow for the block's latency and more.
	localparam int unsigned DRAIN_CYCLES = 150;

	// The testbench's own copy of the material registers.
	cfg_t model_cfg;

	// Results still owed by the block, oldest first.
	result_t pending_strengths[$];

	int unsigned failures;
	bit          hold_off;        // receiver pauses while this is set
	bit          stall_random_on; // receiver draws random stalls per result

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Integer square root, floor, of a 64-bit value.
	function automatic logic [63:0] floor_root(input logic [63:0] n);
		logic [63:0] res;
		logic [63:0] bitv;
		res  = 64'd0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n   = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Expected result of one material point under the current registers.
	function automatic result_t yield_of(input point_t p);
		result_t         r;
		longint          pres;
		longint unsigned ratio;
		longint          coh;
		longint unsigned fric, sq, root, sin30, cos30, dpf, g, k, t;
		longint          acc, strength;
		pres  = longint'(p.pressure);
		ratio = p.weakening_ratio;
		// Ratios above one are treated as full softening.
		if (ratio > 65536)
			ratio = 65536;
		coh = longint'(model_cfg.cohesion_intact) * longint'(65536 - ratio)
			+ longint'(model_cfg.cohesion_softened) * longint'(ratio);
		coh = (coh + 32768) >>> 16;
		fric = (longint'(model_cfg.friction_intact) * (65536 - ratio)
			+ longint'(model_cfg.friction_softened) * ratio + 32768) >> 16;
		sq    = (64'd1 << 32) + fric * fric;
		root  = floor_root(sq << 16);
		sin30 = ((fric << 38) + root / 2) / root;
		cos30 = ((64'd1 << 54) + root / 2) / root;
		if (model_cfg.three_dimensional) begin
			k   = floor_root(64'd12 << 60);
			t   = 3 * 64'd1073741824 - sin30;
			dpf = (k * sin30 + t / 2) / t;
			g   = (k * cos30 + t / 2) / t;
		end else begin
			dpf = sin30;
			g   = cos30;
		end
		acc      = longint'(dpf) * pres + longint'(g) * coh;
		strength = (acc + (64'sd1 <<< 29)) >>> 30;
		if (strength > 64'sd2147483647)
			strength = 64'sd2147483647;
		if (strength < -64'sd2147483648)
			strength = -64'sd2147483648;
		r.tensile_failure = (strength <= 0);
		if (strength < longint'(model_cfg.minimum_strength))
			strength = longint'(model_cfg.minimum_strength);
		r.yield_stress       = strength[31:0];
		r.effective_friction = 23'((dpf + 8192) >> 14);
		return r;
	endfunction

	// One APB write: setup cycle, then access cycle.
	task automatic write_register(input logic [2:0] index, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (index)
			REG_COH_INTACT:  model_cfg.cohesion_intact   = value;
			REG_COH_SOFT:    model_cfg.cohesion_softened = value;
			REG_FRIC_INTACT: model_cfg.friction_intact   = value[22:0];
			REG_FRIC_SOFT:   model_cfg.friction_softened = value[22:0];
			REG_MIN_STRESS:  model_cfg.minimum_strength  = value;
			REG_THREE_D:     model_cfg.three_dimensional = value[0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [31:0] ci, input logic [31:0] cs,
			input logic [22:0] fi, input logic [22:0] fs,
			input logic [31:0] ms, input logic td);
		write_register(REG_COH_INTACT, ci);
		write_register(REG_COH_SOFT, cs);
		write_register(REG_FRIC_INTACT, {9'd0, fi});
		write_register(REG_FRIC_SOFT, {9'd0, fs});
		write_register(REG_MIN_STRESS, ms);
		write_register(REG_THREE_D, {31'd0, td});
	endtask

	// Sends one request, after a random gap when gaps is set, holding it until accepted.
	// The expectation is queued at the acceptance edge, so it always precedes the result.
	task automatic send_point(input logic [31:0] pres, input logic [16:0] ratio,
			input bit gaps);
		int unsigned gap;
		point_t p;
		gap = gaps ? $urandom_range(0, 4) : 0;
		if (gap != 0) begin
			point_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		p.pressure        = pres;
		p.weakening_ratio = ratio;
		point_valid <= 1'b1;
		point       <= p;
		@(posedge clk);
		while (point_stall)
			@(posedge clk);
		pending_strengths.push_back(yield_of(p));
	endtask

	task automatic stop_sending();
		point_valid <= 1'b0;
	endtask

	// Waits until every expected result is in, then lets the pipe settle.
	task automatic drain();
		int unsigned guard;
		stop_sending();
		guard = 0;
		while (pending_strengths.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// A random 17-bit ratio: mostly in range, sometimes above one.
	function automatic logic [16:0] any_ratio();
		case ($urandom_range(0, 7))
			0: return 17'd0;
			1: return ONE_Q16;
			2: return 17'($urandom_range(65537, 131071));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	// Pressures mix full-range values with modest ones so that both saturation and
	// the ordinary range are reached.
	function automatic logic [31:0] any_pressure();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'h7FFFFFFF;
			2: return 32'h80000000;
			default: return 32'($signed($urandom_range(0, 2000000)) - 1000000) << 6;
		endcase
	endfunction

	task automatic random_config();
		logic [22:0] fi, fs;
		fi = ($urandom_range(0, 9) == 0) ? 23'($urandom()) : 23'($urandom_range(0, 4194304));
		fs = ($urandom_range(0, 9) == 0) ? 23'($urandom()) : 23'($urandom_range(0, 4194304));
		write_all($urandom(), $urandom(), fi, fs,
			($urandom_range(0, 1) != 0) ? $urandom() : 32'($signed($urandom_range(0, 200000)) - 100000),
			1'($urandom_range(0, 1)));
	endtask

	// Directed corners: field extremes, both calibrations, ratios at and above one,
	// saturation both ways and the minimum-strength clamp.
	task automatic test_directed();
		write_all(32'h0001_0000, 32'h0000_8000, 23'd65536, 23'd4194304,
			32'hFFFF_0000, 1'b0);
		send_point(32'h0000_0000, 17'd0, 1'b0);
		send_point(32'h7FFF_FFFF, 17'd0, 1'b0);
		send_point(32'h8000_0000, ONE_Q16, 1'b0);
		send_point(32'h0001_0000, 17'd32768, 1'b0);
		send_point(32'hFFFF_FFFF, 17'h1FFFF, 1'b0);
		send_point(32'h5555_5555, 17'h0AAAA, 1'b0);
		send_point(32'hAAAA_AAAA, 17'h15555, 1'b0);
		drain();
		// Strongly tensile case in 3D, with a high minimum strength.
		write_all(32'h8000_0000, 32'h7FFF_FFFF, 23'h7FFFFF, 23'd0,
			32'h0010_0000, 1'b1);
		send_point(32'h8000_0000, 17'd0, 1'b0);
		send_point(32'h7FFF_FFFF, ONE_Q16, 1'b0);
		send_point(32'h0000_0000, 17'd32768, 1'b0);
		send_point(32'hFFF0_0000, 17'd1, 1'b0);
		send_point(32'h0010_0000, 17'd65535, 1'b0);
		drain();
		// Minimum strength at the most negative value; zero friction.
		write_all(32'h0000_0000, 32'h0000_0000, 23'd0, 23'd0, 32'h8000_0000, 1'b1);
		send_point(32'h0000_0000, 17'd0, 1'b0);
		send_point(32'h7FFF_FFFF, 17'd100, 1'b0);
		send_point(32'h8000_0000, ONE_Q16, 1'b0);
		drain();
		write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 23'd4194304, 23'd4194304,
			32'h7FFF_FFFF, 1'b0);
		send_point(32'h7FFF_FFFF, 17'd0, 1'b0);
		send_point(32'h8000_0000, 17'd0, 1'b0);
		drain();
	endtask

	task automatic test_random();
		int unsigned n;
		for (int phase = 0; phase < 8; phase++) begin
			random_config();
			n = (phase == 7) ? 200 : 220;
			stall_random_on = (phase % 3 != 2);
			for (int unsigned i = 0; i < n; i++)
				send_point(any_pressure(), any_ratio(), phase % 3 != 1);
			drain();
		end
		stall_random_on = 1'b1;
	endtask

	// The receiver stops for a long stretch while requests keep coming, so the
	// skid buffer fills and the block has to stall its input.
	task automatic test_backpressure();
		random_config();
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int unsigned i = 0; i < 200; i++)
				send_point(any_pressure(), any_ratio(), 1'b0);
		join
		drain();
	endtask

	// Receiver: draws a fresh stall for each result, or holds off entirely.
	initial begin
		int unsigned wait_cycles;
		result_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			wait_cycles = stall_random_on ? $urandom_range(0, 4) : 0;
			if (hold_off || wait_cycles != 0) begin
				result_stall <= 1'b1;
				@(posedge clk);
				while (hold_off)
					@(posedge clk);
				repeat (wait_cycles) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid && !hold_off)
				@(posedge clk);
		end
	end

	// Checks each accepted result against the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_strengths.size() == 0) begin
				failures++;
				$display("%0t: unexpected result %h", $realtime, result);
			end else begin
				want = pending_strengths.pop_front();
				if (result.yield_stress !== want.yield_stress) begin
					failures++;
					$display("%0t: yield_stress expected %h actual %h",
						$realtime, want.yield_stress, result.yield_stress);
				end
				if (result.tensile_failure !== want.tensile_failure) begin
					failures++;
					$display("%0t: tensile_failure expected %b actual %b",
						$realtime, want.tensile_failure, result.tensile_failure);
				end
				if (result.effective_friction !== want.effective_friction) begin
					failures++;
					$display("%0t: effective_friction expected %h actual %h",
						$realtime, want.effective_friction, result.effective_friction);
				end
			end
		end
	end

	initial begin
		failures        = 0;
		hold_off        = 1'b0;
		stall_random_on = 1'b1;
		model_cfg       = '0;
		arst_n      <= 1'b0;
		point_valid <= 1'b0;
		point       <= '0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		if (pending_strengths.size() != 0) begin
			failures++;
			$display("%0t: %0d results never arrived", $realtime, pending_strengths.size());
		end
		if (failures == 0)
			$display("PASS drucker_prager_yield_stress");
		else
			$display("FAIL drucker_prager_yield_stress");
		$finish;
	end

	// Generous cap on run time.
	initial begin
		#5ms;
		$display("FAIL drucker_prager_yield_stress");
		$finish;
	end

endmodule
